### sv/fbt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// fbt_pkg
// Shared types, codes and tone tables of the FSK bit framer transmitter.
// -----------------------------------------------------------------------------
package fbt_pkg;

  // Item kinds on the input channel
  typedef enum logic [2:0] {
    FUNC_RAW   = 3'd0,
    FUNC_ASYNC = 3'd1,
    FUNC_SYNC  = 3'd2,
    FUNC_FLAG  = 3'd3,
    FUNC_ABORT = 3'd4
  } fbt_func_t;

  // Mode register codes
  typedef enum logic [1:0] {
    MODE_V21_ORIG = 2'd0,
    MODE_V21_ANS  = 2'd1,
    MODE_V23_ORIG = 2'd2,
    MODE_V23_ANS  = 2'd3
  } fbt_mode_t;

  localparam int unsigned SAMPLE_RATE_DEF = 9600;

  localparam int unsigned BAUD_V21     = 300;
  localparam int unsigned BAUD_V23_ORIG = 75;
  localparam int unsigned BAUD_V23_ANS = 1200;

  localparam int unsigned SAMP_MAX = 1023;

  localparam int unsigned FRAME_W = 11;  // longest frame: async character
  localparam int unsigned LEN_W   = 4;
  localparam int unsigned HIST_W  = 5;
  localparam logic [HIST_W-1:0] HIST_STUFF = 5'h1f;

  localparam logic [7:0]  OCT_FLAG   = 8'h7e;
  localparam logic [7:0]  OCT_ABORT  = 8'h7f;
  localparam logic [10:0] ASYNC_STOP = 11'h600;

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

  // One framed item: bits in send order, bit 0 first
  typedef struct packed {
    logic [FRAME_W-1:0] bits;
    logic [LEN_W-1:0]   len;
    logic               stuff;
  } fbt_desc_t;

  // Serialiser status seen by the top level
  typedef struct packed {
    logic              busy;
    logic              pend_stuff;
    logic [HIST_W-1:0] hist;
  } fbt_bstat_t;

  function automatic logic [11:0] mark_hz(input logic [1:0] mode);
    logic [11:0] hz;
    case (mode)
      MODE_V21_ORIG: hz = 12'd980;
      MODE_V21_ANS:  hz = 12'd1650;
      MODE_V23_ORIG: hz = 12'd390;
      MODE_V23_ANS:  hz = 12'd1300;
      default:       hz = 12'd980;
    endcase
    return hz;
  endfunction

  function automatic logic [11:0] space_hz(input logic [1:0] mode);
    logic [11:0] hz;
    case (mode)
      MODE_V21_ORIG: hz = 12'd1180;
      MODE_V21_ANS:  hz = 12'd1850;
      MODE_V23_ORIG: hz = 12'd450;
      MODE_V23_ANS:  hz = 12'd2100;
      default:       hz = 12'd1180;
    endcase
    return hz;
  endfunction

endpackage
`default_nettype wire

### sv/fbt_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// fbt_in_if
// Input word channel: item kind and data byte.
// -----------------------------------------------------------------------------
interface fbt_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [7:0] data;

  modport source (output valid, output func, output data, input ready);
  modport sink   (input valid, input func, input data, output ready);
endinterface
`default_nettype wire

### sv/fbt_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// fbt_out_if
// Result word channel: one tone request per line bit.
// -----------------------------------------------------------------------------
interface fbt_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] tone_hz;
  logic [9:0]  samples;
  logic        bit_value;
  logic        last;

  modport source (output valid, output tone_hz, output samples, output bit_value,
                  output last, input ready);
  modport sink   (input valid, input tone_hz, input samples, input bit_value,
                  input last, output ready);
endinterface
`default_nettype wire

### sv/fbt_front.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// fbt_front
// Classify input words and turn each into a frame descriptor.
// -----------------------------------------------------------------------------
module fbt_front (
  input  wire logic         in_valid,
  input  wire logic [2:0]   in_func,
  input  wire logic [7:0]   in_data,
  output logic              push,
  output fbt_pkg::fbt_desc_t desc
);

  logic [7:0] oct;
  logic       known;

  always_comb begin
    oct   = 8'h00;
    known = 1'b1;
    desc  = '0;
    case (in_func)
      fbt_pkg::FUNC_RAW: begin
        desc.bits[0] = |in_data;
        desc.len     = fbt_pkg::LEN_W'(1);
      end
      fbt_pkg::FUNC_ASYNC: begin
        // start bit, data LSB first, two stop bits
        desc.bits = {3'b000, in_data} << 1 | fbt_pkg::ASYNC_STOP;
        desc.len  = fbt_pkg::LEN_W'(fbt_pkg::FRAME_W);
      end
      fbt_pkg::FUNC_SYNC: begin
        oct        = in_data;
        desc.stuff = 1'b1;
        desc.len   = fbt_pkg::LEN_W'(8);
      end
      fbt_pkg::FUNC_FLAG: begin
        oct      = fbt_pkg::OCT_FLAG;
        desc.len = fbt_pkg::LEN_W'(8);
      end
      fbt_pkg::FUNC_ABORT: begin
        oct      = fbt_pkg::OCT_ABORT;
        desc.len = fbt_pkg::LEN_W'(8);
      end
      default: begin
        known = 1'b0;
      end
    endcase
    // octets go out MSB first: reverse into send order
    if (in_func inside {fbt_pkg::FUNC_SYNC, fbt_pkg::FUNC_FLAG, fbt_pkg::FUNC_ABORT}) begin
      for (int i = 0; i < 8; i++) begin
        desc.bits[i] = oct[7-i];
      end
    end
  end

  // unknown kinds are taken and dropped
  assign push = in_valid && known;

endmodule
`default_nettype wire

### sv/fbt_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// fbt_queue
// Short descriptor queue between the classifier and the serialiser.
// -----------------------------------------------------------------------------
module fbt_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire fbt_pkg::fbt_desc_t push_desc,
  output logic                    full,
  output logic                    q_valid,
  output fbt_pkg::fbt_desc_t      q_desc,
  input  wire logic               pop
);

  localparam int unsigned AW = fbt_pkg::Q_AW;

  fbt_pkg::fbt_desc_t slot_r [fbt_pkg::Q_DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == (AW+1)'(fbt_pkg::Q_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_desc  = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? AW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? AW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = (AW+1)'(cnt_r + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = (AW+1)'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule
`default_nettype wire

### sv/fbt_back.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// fbt_back
// Serialise frame descriptors into tone requests, with zero stuffing.
// -----------------------------------------------------------------------------
module fbt_back #(
  parameter int unsigned SAMPLE_RATE = fbt_pkg::SAMPLE_RATE_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_wdata,
  input  wire logic               q_valid,
  input  wire fbt_pkg::fbt_desc_t q_desc,
  output logic                    pop,
  fbt_out_if.source               out_ch,
  output fbt_pkg::fbt_bstat_t     stat
);

  localparam int unsigned DivV21  = SAMPLE_RATE / fbt_pkg::BAUD_V21;
  localparam int unsigned DivV23O = SAMPLE_RATE / fbt_pkg::BAUD_V23_ORIG;
  localparam int unsigned DivV23A = SAMPLE_RATE / fbt_pkg::BAUD_V23_ANS;
  localparam logic [9:0] SampV21  =
    (DivV21 > fbt_pkg::SAMP_MAX) ? 10'd1023 : 10'(DivV21);
  localparam logic [9:0] SampV23O =
    (DivV23O > fbt_pkg::SAMP_MAX) ? 10'd1023 : 10'(DivV23O);
  localparam logic [9:0] SampV23A =
    (DivV23A > fbt_pkg::SAMP_MAX) ? 10'd1023 : 10'(DivV23A);

  localparam int unsigned HW = fbt_pkg::HIST_W;
  localparam int unsigned LW = fbt_pkg::LEN_W;
  localparam int unsigned FW = fbt_pkg::FRAME_W;

  logic [1:0]    mode_r, mode_nxt;
  logic [HW-1:0] hist_r, hist_nxt;
  logic          busy_r, busy_nxt;
  logic          pend_r, pend_nxt;
  logic          stuff_r, stuff_nxt;
  logic [FW-1:0] sh_r, sh_nxt;
  logic [LW-1:0] rem_r, rem_nxt;
  logic          ov_r, ov_nxt;
  logic [11:0]   hz_r, hz_nxt;
  logic [9:0]    samp_r, samp_nxt;
  logic          bit_r, bit_nxt;
  logic          last_r, last_nxt;

  logic          emit, lastb, bitv, stuff_hit;
  logic [HW-1:0] hist_sh;
  logic [9:0]    samp_cur;

  always_comb begin
    case (mode_r)
      fbt_pkg::MODE_V21_ORIG: samp_cur = SampV21;
      fbt_pkg::MODE_V21_ANS:  samp_cur = SampV21;
      fbt_pkg::MODE_V23_ORIG: samp_cur = SampV23O;
      fbt_pkg::MODE_V23_ANS:  samp_cur = SampV23A;
      default:                samp_cur = SampV21;
    endcase
  end

  assign emit = busy_r && (!ov_r || out_ch.ready);
  assign pop  = !busy_r && q_valid;

  assign bitv      = pend_r ? 1'b0 : sh_r[0];
  assign hist_sh   = {hist_r[HW-2:0], bitv};
  assign stuff_hit = !pend_r && stuff_r && (hist_sh == fbt_pkg::HIST_STUFF);
  assign lastb     = pend_r ? (rem_r == '0) : ((rem_r == LW'(1)) && !stuff_hit);

  always_comb begin
    mode_nxt  = mode_r;
    hist_nxt  = hist_r;
    busy_nxt  = busy_r;
    pend_nxt  = pend_r;
    stuff_nxt = stuff_r;
    sh_nxt    = sh_r;
    rem_nxt   = rem_r;
    ov_nxt    = ov_r;
    hz_nxt    = hz_r;
    samp_nxt  = samp_r;
    bit_nxt   = bit_r;
    last_nxt  = last_r;

    if (pop) begin
      sh_nxt    = q_desc.bits;
      rem_nxt   = q_desc.len;
      stuff_nxt = q_desc.stuff;
      pend_nxt  = 1'b0;
      busy_nxt  = 1'b1;
    end

    if (emit) begin
      hist_nxt = hist_sh;
      pend_nxt = stuff_hit;
      if (!pend_r) begin
        sh_nxt  = sh_r >> 1;
        rem_nxt = LW'(rem_r - 1'b1);
      end
      busy_nxt = !lastb;
      ov_nxt   = 1'b1;
      hz_nxt   = bitv ? fbt_pkg::mark_hz(mode_r) : fbt_pkg::space_hz(mode_r);
      samp_nxt = samp_cur;
      bit_nxt  = bitv;
      last_nxt = lastb;
    end else if (out_ch.ready) begin
      ov_nxt = 1'b0;
    end

    // mode write clears the history and any pending stuffed zero
    if (cfg_we) begin
      mode_nxt = cfg_wdata;
      hist_nxt = '0;
      pend_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= fbt_pkg::MODE_V21_ORIG;
      hist_r <= '0;
      busy_r <= 1'b0;
      pend_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      hist_r <= hist_nxt;
      busy_r <= busy_nxt;
      pend_r <= pend_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stuff_r <= stuff_nxt;
    sh_r    <= sh_nxt;
    rem_r   <= rem_nxt;
    hz_r    <= hz_nxt;
    samp_r  <= samp_nxt;
    bit_r   <= bit_nxt;
    last_r  <= last_nxt;
  end

  assign out_ch.valid     = ov_r;
  assign out_ch.tone_hz   = hz_r;
  assign out_ch.samples   = samp_r;
  assign out_ch.bit_value = bit_r;
  assign out_ch.last      = last_r;

  assign stat.busy       = busy_r;
  assign stat.pend_stuff = pend_r;
  assign stat.hist       = hist_r;

endmodule
`default_nettype wire

### sv/fsk_bit_framer_tx_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// fsk_bit_framer_tx_unit
// Bit framer for a V.21 / V.23 FSK transmitter with HDLC zero stuffing.
// -----------------------------------------------------------------------------
// Usage:
//   in_ch  : one word per item (func, data). Raw bit, async character,
//            stuffed sync octet, flag or abort. Unknown kinds are taken and
//            dropped without any result.
//   out_ch : one word per line bit: tone frequency, duration in samples,
//            the bit itself and a last marker on the final bit of an item.
//   cfg_we / cfg_wdata : write the mode; a write also clears the shared
//            five-bit history. Write only while the block is idle.
// Timing:
//   An accepted word reaches the descriptor queue in the same cycle; the
//   serialiser loads it once idle and registers the first result on out_ch.
//   The serialiser then gives one bit per cycle while out_ch is not stalled,
//   and loads a new item only after the last bit of the one before. An item
//   is one raw bit, an 11-bit async character or a sync octet plus stuffed
//   zeros. The serialiser sets the bit rate.
//   The input side keeps taking words until the two-entry queue is full.
// Reset: rst_n, synchronous, active low; clears mode to V.21 originate, the
//   history, the queue and the output valid flag.
// Stall: a stalled receiver holds the output word; the serialiser holds,
//   the queue fills and in_ch.ready drops once it is full.
// -----------------------------------------------------------------------------
module fsk_bit_framer_tx_unit #(
  parameter int unsigned SAMPLE_RATE = fbt_pkg::SAMPLE_RATE_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_wdata,
  fbt_in_if.sink          in_ch,
  fbt_out_if.source       out_ch
);

  logic                push;
  logic                q_full;
  logic                q_valid;
  logic                pop;
  fbt_pkg::fbt_desc_t  push_desc;
  fbt_pkg::fbt_desc_t  q_desc;
  fbt_pkg::fbt_bstat_t bstat;

  // front: classify and frame; hold input while the queue is full
  assign in_ch.ready = !q_full;

  fbt_front u_front (
    .in_valid (in_ch.valid),
    .in_func  (in_ch.func),
    .in_data  (in_ch.data),
    .push     (push),
    .desc     (push_desc)
  );

  fbt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_desc    (q_desc),
    .pop       (pop)
  );

  // back: serialise, stuff, map to tones
  fbt_back #(
    .SAMPLE_RATE (SAMPLE_RATE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_desc    (q_desc),
    .pop       (pop),
    .out_ch    (out_ch),
    .stat      (bstat)
  );

  // a mode write leaves the history clear
  a_cfg_clears_hist: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (bstat.hist == '0))
    else $error("history not cleared after mode write");

  // a stuffed zero is only pending right after five ones
  a_pend_after_ones: assert property (@(posedge clk) disable iff (!rst_n)
    bstat.pend_stuff |-> (bstat.hist == fbt_pkg::HIST_STUFF))
    else $error("stuffed zero pending without five ones");

  // an idle serialiser has no stuffed zero left over
  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    !bstat.busy |-> !bstat.pend_stuff)
    else $error("stuffed zero lost at end of item");

  // the serialiser only loads while idle
  a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (!bstat.busy && q_valid))
    else $error("queue popped while serialiser busy");

endmodule
`default_nettype wire
